// ===== rtl/core/matrix_multiply_core_assert.svh =====
// Assertion macros shared by the matrix multiply core modules.
`ifndef MATRIX_MULTIPLY_CORE_ASSERT_SVH
`define MATRIX_MULTIPLY_CORE_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define MM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define MM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/mm_pkg.sv =====
// Shared types and constants for the matrix multiply core.
package mm_pkg;

    // Element and configuration widths
    localparam int ELEM_W    = 32;
    localparam int DIM_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int FRAC_W    = 16;

    typedef logic signed [ELEM_W-1:0] t_elem;
    typedef logic [DIM_W-1:0]         t_dim;
    typedef logic [CFG_IDX_W-1:0]     t_cfg_idx;

    // Configuration register indexes
    localparam t_cfg_idx CFG_ROWS_A    = 2'd0;
    localparam t_cfg_idx CFG_INNER_DIM = 2'd1;
    localparam t_cfg_idx CFG_COLS_B    = 2'd2;

    localparam t_dim DIM_RESET = 4'd8;

    // Q16.16 saturation limits
    localparam t_elem Q_MAX = 32'sh7FFF_FFFF;
    localparam t_elem Q_MIN = 32'sh8000_0000;

    // Tags that travel with each store read into the MAC pipeline
    typedef struct packed {
        logic valid;
        logic first;  // first term of a dot product
        logic lastk;  // last term of a dot product
        logic fin;    // term belongs to the final product element
    } t_mac_ctl;

endpackage

// ===== rtl/core/mm_ifs.sv =====
// Handshake channel interfaces: input items, result items, configuration writes.
interface mm_in_if;
    import mm_pkg::*;
    logic  valid;
    logic  ready;
    t_elem element;
    logic  to_right;

    modport source (output valid, output element, output to_right, input ready);
    modport sink   (input valid, input element, input to_right, output ready);
endinterface

interface mm_out_if;
    import mm_pkg::*;
    logic  valid;
    logic  ready;
    t_elem product;
    logic  saturated;
    logic  last;

    modport source (output valid, output product, output saturated, output last,
                    input ready);
    modport sink   (input valid, input product, input saturated, input last,
                    output ready);
endinterface

interface mm_cfg_if;
    import mm_pkg::*;
    logic     valid;
    logic     ready;
    t_cfg_idx index;
    t_dim     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/matrix_multiply_core.sv =====
// Fixed-point matrix product C = A * B: elements of A and B stream in row-major
// order, one item per cycle, each tagged for A or B; once the last B element is
// taken the core stops accepting input and returns rows_a x cols_b Q16.16 results
// in row-major order, last set on the final one. Each result is summed one term
// per cycle through the single read port of each matrix store, then passes the
// multiply and accumulate stages and is saturated into the result register, after
// which the next element starts. Sums are exact, floored to Q16.16 and clipped,
// with saturated flagged. Dimension registers take 0 as 1 and clamp above MAX_DIM;
// write them only while the core is idle. Reading store entries never written
// since reset gives undefined results.
module matrix_multiply_core #(
    parameter int MAX_DIM = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mm_in_if.sink      i_item,
    mm_out_if.source   o_result,
    mm_cfg_if.sink     i_cfg
);
    import mm_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DW    = $clog2(MAX_DIM + 1);

    t_dim             r_rows_a;
    t_dim             r_inner_dim;
    t_dim             r_cols_b;

    logic [DW-1:0]    w_ra;
    logic [DW-1:0]    w_n;
    logic [DW-1:0]    w_m;
    logic             w_mac_busy;
    logic             w_wr_en;
    logic [AW-1:0]    w_wr_addr;
    logic             w_rd_en;
    logic [AW-1:0]    w_rd_a_addr;
    logic [AW-1:0]    w_rd_b_addr;
    t_mac_ctl         w_mac_ctl;
    t_elem            w_a_data;
    t_elem            w_b_data;

    // Effective dimension: zero acts as one, clamp at MAX_DIM
    function automatic logic [DW-1:0] eff_dim(input t_dim v);
        if (v == '0) begin
            return DW'(1);
        end else if (int'(v) > MAX_DIM) begin
            return DW'(MAX_DIM);
        end else begin
            return DW'(v);
        end
    endfunction

    // Configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a    <= DIM_RESET;
            r_inner_dim <= DIM_RESET;
            r_cols_b    <= DIM_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_ROWS_A:    r_rows_a    <= i_cfg.data;
                CFG_INNER_DIM: r_inner_dim <= i_cfg.data;
                CFG_COLS_B:    r_cols_b    <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    assign w_ra = eff_dim(r_rows_a);
    assign w_n  = eff_dim(r_inner_dim);
    assign w_m  = eff_dim(r_cols_b);

    // Sequencer
    mm_seq #(
        .MAX_DIM (MAX_DIM)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ra        (w_ra),
        .i_n         (w_n),
        .i_m         (w_m),
        .i_in_valid  (i_item.valid),
        .i_in_right  (i_item.to_right),
        .i_mac_busy  (w_mac_busy),
        .o_in_ready  (i_item.ready),
        .o_wr_en     (w_wr_en),
        .o_wr_addr   (w_wr_addr),
        .o_rd_en     (w_rd_en),
        .o_rd_a_addr (w_rd_a_addr),
        .o_rd_b_addr (w_rd_b_addr),
        .o_mac_ctl   (w_mac_ctl)
    );

    // Matrix stores
    mm_store #(
        .MAX_DIM (MAX_DIM)
    ) u_store (
        .i_clk       (i_clk),
        .i_wr_en     (w_wr_en),
        .i_wr_right  (i_item.to_right),
        .i_wr_addr   (w_wr_addr),
        .i_wr_data   (i_item.element),
        .i_rd_en     (w_rd_en),
        .i_rd_a_addr (w_rd_a_addr),
        .i_rd_b_addr (w_rd_b_addr),
        .o_a_data    (w_a_data),
        .o_b_data    (w_b_data)
    );

    // Multiply-accumulate and result register
    mm_mac #(
        .MAX_DIM (MAX_DIM)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_mac_ctl),
        .i_a_data (w_a_data),
        .i_b_data (w_b_data),
        .o_busy   (w_mac_busy),
        .o_res    (o_result)
    );

`include "matrix_multiply_core_assert.svh"

    `MM_ASSERT_NOW(a_load_idle, i_item.ready, !w_mac_busy,
                   "input accepted while a product is in flight")

endmodule

// ===== rtl/core/mm_store.sv =====
// Left and right matrix stores: one write port, registered read ports.
module mm_store #(
    parameter int  MAX_DIM = 8,
    localparam int DEPTH   = MAX_DIM * MAX_DIM,
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic            i_clk,
    input  logic            i_wr_en,
    input  logic            i_wr_right,
    input  logic [AW-1:0]   i_wr_addr,
    input  mm_pkg::t_elem   i_wr_data,
    input  logic            i_rd_en,
    input  logic [AW-1:0]   i_rd_a_addr,
    input  logic [AW-1:0]   i_rd_b_addr,
    output mm_pkg::t_elem   o_a_data,
    output mm_pkg::t_elem   o_b_data
);
    import mm_pkg::*;

    t_elem r_left_mem  [DEPTH];
    t_elem r_right_mem [DEPTH];
    t_elem r_a_data;
    t_elem r_b_data;

    // Left matrix: write during load, read during compute
    always_ff @(posedge i_clk) begin
        if (i_wr_en && !i_wr_right) begin
            r_left_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_a_data <= r_left_mem[i_rd_a_addr];
        end
    end

    // Right matrix
    always_ff @(posedge i_clk) begin
        if (i_wr_en && i_wr_right) begin
            r_right_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_b_data <= r_right_mem[i_rd_b_addr];
        end
    end

    assign o_a_data = r_a_data;
    assign o_b_data = r_b_data;

endmodule

// ===== rtl/core/mm_mac.sv =====
// Multiply-accumulate pipeline with Q16.16 truncation, saturation and result register.
module mm_mac #(
    parameter int  MAX_DIM = 8,
    localparam int PROD_W  = 2 * mm_pkg::ELEM_W,
    localparam int ACC_W   = PROD_W + $clog2(MAX_DIM) + 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mm_pkg::t_mac_ctl i_ctl,
    input  mm_pkg::t_elem    i_a_data,
    input  mm_pkg::t_elem    i_b_data,
    output logic             o_busy,
    mm_out_if.source         o_res
);
    import mm_pkg::*;

    // Bits of the sum above the Q16.16 result range must be pure sign
    localparam int HI_LSB = FRAC_W + ELEM_W - 1;

    t_mac_ctl                   r_s1;
    t_mac_ctl                   r_s2;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]    r_acc;
    logic                       r_s3_done;
    logic                       r_s3_fin;
    logic                       r_out_valid;
    t_elem                      r_out_product;
    logic                       r_out_sat;
    logic                       r_out_last;

    logic [ACC_W-1:0]           w_prod_ext;
    logic [ACC_W-HI_LSB-1:0]    w_hi;
    logic                       w_in_range;
    t_elem                      w_sat_val;

    // Stage tags: s1 lines up with store read data, s2 with the product
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_s2 <= '0;
        end else begin
            r_s1 <= i_ctl;
            r_s2 <= r_s1;
        end
    end

    // Multiply stage
    always_ff @(posedge i_clk) begin
        if (r_s1.valid) begin
            r_prod <= i_a_data * i_b_data;
        end
    end

    // Accumulate at full width
    assign w_prod_ext = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};

    always_ff @(posedge i_clk) begin
        if (r_s2.valid) begin
            if (r_s2.first) begin
                r_acc <= w_prod_ext;
            end else begin
                r_acc <= r_acc + w_prod_ext;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_done <= 1'b0;
            r_s3_fin  <= 1'b0;
        end else begin
            r_s3_done <= r_s2.valid && r_s2.lastk;
            r_s3_fin  <= r_s2.fin;
        end
    end

    // Drop 16 fraction bits (floor), then clip to Q16.16
    assign w_hi       = r_acc[ACC_W-1:HI_LSB];
    assign w_in_range = (w_hi == '0) || (w_hi == '1);
    assign w_sat_val  = w_in_range ? r_acc[FRAC_W+ELEM_W-1:FRAC_W]
                                   : (r_acc[ACC_W-1] ? Q_MIN : Q_MAX);

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_s3_done) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s3_done) begin
            r_out_product <= w_sat_val;
            r_out_sat     <= !w_in_range;
            r_out_last    <= r_s3_fin;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.product   = r_out_product;
    assign o_res.saturated = r_out_sat;
    assign o_res.last      = r_out_last;

    assign o_busy = r_s1.valid || r_s2.valid || r_s3_done || r_out_valid;

`include "matrix_multiply_core_assert.svh"

    `MM_ASSERT_NOW(a_no_overwrite, r_s3_done, !r_out_valid, "result overwrites pending item")
    `MM_ASSERT_NOW(a_sat_clip, r_out_valid && r_out_sat,
                   o_res.product == Q_MAX || o_res.product == Q_MIN,
                   "saturated item not at a range limit")

endmodule

// ===== rtl/core/mm_seq.sv =====
// Load counters and compute sequencer: store addressing and MAC term tags.
module mm_seq #(
    parameter int  MAX_DIM = 8,
    localparam int DEPTH   = MAX_DIM * MAX_DIM,
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW      = $clog2(DEPTH + 1),
    localparam int DW      = $clog2(MAX_DIM + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [DW-1:0]    i_ra,
    input  logic [DW-1:0]    i_n,
    input  logic [DW-1:0]    i_m,
    input  logic             i_in_valid,
    input  logic             i_in_right,
    input  logic             i_mac_busy,
    output logic             o_in_ready,
    output logic             o_wr_en,
    output logic [AW-1:0]    o_wr_addr,
    output logic             o_rd_en,
    output logic [AW-1:0]    o_rd_a_addr,
    output logic [AW-1:0]    o_rd_b_addr,
    output mm_pkg::t_mac_ctl o_mac_ctl
);
    import mm_pkg::*;

    typedef enum logic [2:0] {
        S_LOAD  = 3'b001,
        S_ISSUE = 3'b010,
        S_WAIT  = 3'b100
    } t_seq_state;

    t_seq_state      r_state,     n_state;
    logic [CW-1:0]   r_left_cnt,  n_left_cnt;
    logic [CW-1:0]   r_right_cnt, n_right_cnt;
    logic [CW-1:0]   r_row_base,  n_row_base;
    logic [CW-1:0]   r_a_ptr,     n_a_ptr;
    logic [CW-1:0]   r_b_ptr,     n_b_ptr;
    logic [DW-1:0]   r_i,         n_i;
    logic [DW-1:0]   r_j,         n_j;
    logic [DW-1:0]   r_k,         n_k;
    logic            r_fin_pend,  n_fin_pend;

    logic [CW-1:0]   w_left_size;
    logic [CW-1:0]   w_right_size;
    logic            w_in_acc;
    logic            w_lastk;
    logic            w_fin;

    assign w_left_size  = CW'(i_ra) * CW'(i_n);
    assign w_right_size = CW'(i_n) * CW'(i_m);

    assign o_in_ready = (r_state == S_LOAD);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign o_wr_addr  = i_in_right ? r_right_cnt[AW-1:0] : r_left_cnt[AW-1:0];

    assign w_lastk = (r_k == i_n - DW'(1));
    assign w_fin   = (r_i == i_ra - DW'(1)) && (r_j == i_m - DW'(1));

    assign o_rd_a_addr = r_a_ptr[AW-1:0];
    assign o_rd_b_addr = r_b_ptr[AW-1:0];

    always_comb begin
        n_state     = r_state;
        n_left_cnt  = r_left_cnt;
        n_right_cnt = r_right_cnt;
        n_row_base  = r_row_base;
        n_a_ptr     = r_a_ptr;
        n_b_ptr     = r_b_ptr;
        n_i         = r_i;
        n_j         = r_j;
        n_k         = r_k;
        n_fin_pend  = r_fin_pend;
        o_wr_en     = 1'b0;
        o_rd_en     = 1'b0;
        o_mac_ctl   = '0;

        case (r_state)
            // Fill stores; the right matrix completing starts the product
            S_LOAD: begin
                if (w_in_acc) begin
                    if (!i_in_right) begin
                        if (r_left_cnt < w_left_size) begin
                            o_wr_en    = 1'b1;
                            n_left_cnt = r_left_cnt + CW'(1);
                        end
                    end else begin
                        if (r_right_cnt < w_right_size) begin
                            o_wr_en     = 1'b1;
                            n_right_cnt = r_right_cnt + CW'(1);
                        end
                        if (n_right_cnt >= w_right_size) begin
                            n_state     = S_ISSUE;
                            n_left_cnt  = '0;
                            n_right_cnt = '0;
                            n_row_base  = '0;
                            n_a_ptr     = '0;
                            n_b_ptr     = '0;
                            n_i         = '0;
                            n_j         = '0;
                            n_k         = '0;
                        end
                    end
                end
            end
            // One dot-product term per cycle: A walks the row, B the column
            S_ISSUE: begin
                o_rd_en         = 1'b1;
                o_mac_ctl.valid = 1'b1;
                o_mac_ctl.first = (r_k == '0);
                o_mac_ctl.lastk = w_lastk;
                o_mac_ctl.fin   = w_fin;
                if (!w_lastk) begin
                    n_k     = r_k + DW'(1);
                    n_a_ptr = r_a_ptr + CW'(1);
                    n_b_ptr = r_b_ptr + CW'(i_m);
                end else begin
                    n_k        = '0;
                    n_state    = S_WAIT;
                    n_fin_pend = w_fin;
                    if (r_j == i_m - DW'(1)) begin
                        n_j        = '0;
                        n_i        = r_i + DW'(1);
                        n_row_base = r_row_base + CW'(i_n);
                        n_a_ptr    = r_row_base + CW'(i_n);
                        n_b_ptr    = '0;
                    end else begin
                        n_j     = r_j + DW'(1);
                        n_a_ptr = r_row_base;
                        n_b_ptr = CW'(r_j) + CW'(1);
                    end
                end
            end
            // Hold until the element has drained and been taken
            S_WAIT: begin
                if (!i_mac_busy) begin
                    n_state = r_fin_pend ? S_LOAD : S_ISSUE;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_left_cnt  <= '0;
            r_right_cnt <= '0;
            r_fin_pend  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_left_cnt  <= n_left_cnt;
            r_right_cnt <= n_right_cnt;
            r_fin_pend  <= n_fin_pend;
        end
    end

    // Loop indexes and pointers are only meaningful in the compute states
    always_ff @(posedge i_clk) begin
        r_row_base <= n_row_base;
        r_a_ptr    <= n_a_ptr;
        r_b_ptr    <= n_b_ptr;
        r_i        <= n_i;
        r_j        <= n_j;
        r_k        <= n_k;
    end

`include "matrix_multiply_core_assert.svh"

    `MM_ASSERT_NOW(a_rd_in_range, r_state == S_ISSUE,
                   r_a_ptr < w_left_size && r_b_ptr < w_right_size,
                   "store read outside matrix")
    `MM_ASSERT_NEXT(a_lastk_waits, o_mac_ctl.valid && o_mac_ctl.lastk,
                    r_state == S_WAIT, "issue continued past a dot product")

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the fixed-point matrix multiply core.
`timescale 1ns / 100ps

module tb;
    import mm_pkg::*;

    localparam int MAX_DIM        = 8;
    localparam int STORE_DEPTH    = MAX_DIM * MAX_DIM;
    localparam int DRAIN_CYCLES   = 2 * (MAX_DIM + 5);
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTING_LOADS  = 8;

    // What queueing one element does to the load counters
    typedef enum int {LD_IGNORED, LD_STORED, LD_PRODUCT} t_load;

    typedef struct packed {
        t_elem element;
        logic  to_right;
        logic  hold;      // wait for every outstanding product before sending
    } t_elem_item;

    typedef struct packed {
        t_elem product;
        logic  saturated;
        logic  last;
    } t_product;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mm_in_if  in_ch();
    mm_out_if out_ch();
    mm_cfg_if cfg_ch();

    matrix_multiply_core #(.MAX_DIM(MAX_DIM)) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (in_ch),
        .o_result (out_ch),
        .i_cfg    (cfg_ch)
    );

    always #5 i_clk = ~i_clk;

    // Elements waiting to be sent, products waiting to be seen
    t_elem_item load_q[$];
    t_product   product_q[$];

    // Predictor state
    t_dim       rows_reg  = DIM_RESET;
    t_dim       inner_reg = DIM_RESET;
    t_dim       cols_reg  = DIM_RESET;
    t_elem      left_mem [STORE_DEPTH];
    t_elem      right_mem[STORE_DEPTH];
    logic [6:0] left_cnt  = '0;
    logic [6:0] right_cnt = '0;

    // Generator-side counters, used to keep reads within written entries
    logic [6:0]  gen_left_cnt  = '0;
    logic [6:0]  gen_right_cnt = '0;
    int unsigned gen_left_hw   = 0;
    int unsigned gen_loads     = 0;

    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    int n_errors      = 0;
    int n_items       = 0;
    int n_products    = 0;
    int n_clipped     = 0;
    int n_cfg_writes  = 0;
    int idle_cycles   = 0;
    logic in_taken    = 1'b0;

    logic any_accept;
    assign any_accept = (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                        (cfg_ch.valid && cfg_ch.ready);

    // Register value to effective dimension: 0 acts as 1, clamp at MAX_DIM
    function automatic int unsigned dim_of(t_dim v);
        if (v == 0) return 1;
        if (v > MAX_DIM) return MAX_DIM;
        return v;
    endfunction

    function automatic void note_error(string msg);
        n_errors++;
        if (n_errors <= 10) $display("mismatch: %s", msg);
    endfunction

    // Predictor: load one accepted element, queue the product matrix when B completes
    function automatic void load_element(t_elem e, logic right);
        int unsigned ra, n, m, i, j, k;
        logic signed [127:0] acc;
        logic signed [63:0]  a, b;
        t_product            r;
        ra = dim_of(rows_reg);
        n  = dim_of(inner_reg);
        m  = dim_of(cols_reg);
        if (!right) begin
            if (left_cnt < ra * n) begin
                left_mem[left_cnt] = e;
                left_cnt = left_cnt + 1'b1;
            end
            return;
        end
        if (right_cnt < n * m) begin
            right_mem[right_cnt] = e;
            right_cnt = right_cnt + 1'b1;
        end
        if (right_cnt < n * m) return;
        for (i = 0; i < ra; i++) begin
            for (j = 0; j < m; j++) begin
                acc = '0;
                for (k = 0; k < n; k++) begin
                    a   = left_mem[(i * n + k) % STORE_DEPTH];
                    b   = right_mem[(k * m + j) % STORE_DEPTH];
                    acc = acc + a * b;
                end
                // floor to Q16.16, then clip
                acc = acc >>> FRAC_W;
                if (acc > 128'sd2147483647) begin
                    r.product   = Q_MAX;
                    r.saturated = 1'b1;
                end else if (acc < -(128'sd2147483648)) begin
                    r.product   = Q_MIN;
                    r.saturated = 1'b1;
                end else begin
                    r.product   = acc[31:0];
                    r.saturated = 1'b0;
                end
                r.last = (i == ra - 1) && (j == m - 1);
                product_q.insert(product_q.size(), r);
            end
        end
        left_cnt  = '0;
        right_cnt = '0;
    endfunction

    // Queue one element for the driver, tracking the counters it will move
    function automatic t_load queue_element(t_elem e, logic right, logic hold);
        int unsigned ra, n, m;
        t_load       res;
        ra  = dim_of(rows_reg);
        n   = dim_of(inner_reg);
        m   = dim_of(cols_reg);
        res = LD_IGNORED;
        load_q.insert(load_q.size(), t_elem_item'{element: e, to_right: right, hold: hold});
        if (!right) begin
            if (gen_left_cnt < ra * n) begin
                if (gen_left_cnt + 1 > gen_left_hw) gen_left_hw = gen_left_cnt + 1;
                gen_left_cnt = gen_left_cnt + 1'b1;
                res = LD_STORED;
            end
        end else begin
            if (gen_right_cnt < n * m) begin
                gen_right_cnt = gen_right_cnt + 1'b1;
                res = LD_STORED;
            end
            if (gen_right_cnt >= n * m) begin
                gen_left_cnt  = '0;
                gen_right_cnt = '0;
                res = LD_PRODUCT;
            end
        end
        if (res != LD_IGNORED) gen_loads++;
        return res;
    endfunction

    function automatic t_elem rand_elem();
        logic [23:0] s;
        s = 24'($urandom());
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(3))
                    0:       return Q_MAX;
                    1:       return Q_MIN;
                    2:       return '0;
                    default: return '1;
                endcase
            end
            1, 2:    return t_elem'($urandom());
            default: return t_elem'({{8{s[23]}}, s});
        endcase
    endfunction

    // B element; if it would complete B over unwritten A entries, fill A first
    function automatic t_load queue_right(t_elem e, logic hold);
        int unsigned ra, n, m;
        ra = dim_of(rows_reg);
        n  = dim_of(inner_reg);
        m  = dim_of(cols_reg);
        if (gen_right_cnt + 1 >= n * m && gen_left_hw < ra * n) begin
            while (gen_left_cnt < ra * n) void'(queue_element(rand_elem(), 1'b0, hold));
        end
        return queue_element(e, 1'b1, hold);
    endfunction

    // Complete A from where it stands, then B until the product fires
    function automatic void queue_product(logic hold);
        int unsigned ra, n;
        logic        h;
        ra = dim_of(rows_reg);
        n  = dim_of(inner_reg);
        h  = hold;
        while (gen_left_cnt < ra * n) begin
            void'(queue_element(rand_elem(), 1'b0, h));
            h = 1'b0;
        end
        while (queue_element(rand_elem(), 1'b1, h) != LD_PRODUCT) h = 1'b0;
    endfunction

    function automatic t_dim rand_dim();
        if ($urandom_range(9) < 7) return t_dim'($urandom_range(1, 4));
        return t_dim'($urandom_range(0, 15));
    endfunction

    // Block is idle: all items sent, all products seen, pipeline drained
    task automatic wait_quiet();
        while (load_q.size() != 0 || in_ch.valid || product_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, t_dim val);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            CFG_ROWS_A:    rows_reg  = val;
            CFG_INNER_DIM: inner_reg = val;
            CFG_COLS_B:    cols_reg  = val;
            default: ;
        endcase
        n_cfg_writes++;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_dims(t_dim ra, t_dim n, t_dim m);
        wait_quiet();
        write_reg(CFG_ROWS_A, ra);
        write_reg(CFG_INNER_DIM, n);
        write_reg(CFG_COLS_B, m);
    endtask

    // Driver: inputs change on the falling edge
    always @(negedge i_clk) begin
        if (in_taken) void'(load_q.pop_front());
        if (in_ch.valid && !in_taken) begin
            // hold the item until it is taken
        end else if (load_q.size() != 0 && (!load_q[0].hold || product_q.size() == 0) &&
                     $urandom_range(99) >= src_idle_pct) begin
            in_ch.valid    <= 1'b1;
            in_ch.element  <= load_q[0].element;
            in_ch.to_right <= load_q[0].to_right;
        end else begin
            in_ch.valid <= 1'b0;
        end
        out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // Monitor: predict on accepted items, check accepted results
    always @(posedge i_clk) begin
        t_product got, want;
        in_taken <= i_rst_n && in_ch.valid && in_ch.ready;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            n_items++;
            load_element(in_ch.element, in_ch.to_right);
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = '{product: out_ch.product, saturated: out_ch.saturated, last: out_ch.last};
            n_products++;
            if (got.saturated) n_clipped++;
            if (product_q.size() == 0) begin
                note_error($sformatf("unexpected product=%h saturated=%b last=%b",
                                     got.product, got.saturated, got.last));
            end else begin
                want = product_q.pop_front();
                if (got !== want)
                    note_error($sformatf({"product %0d: expected product=%h saturated=%b ",
                                          "last=%b, got product=%h saturated=%b last=%b"},
                                         n_products, want.product, want.saturated, want.last,
                                         got.product, got.saturated, got.last));
            end
        end
    end

    // Watchdog on cycles without any accepted item
    always @(posedge i_clk) begin
        if (any_accept) idle_cycles <= 0;
        else            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no item accepted for %0d cycles", idle_cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Stimulus and end of run
    initial begin
        int ph, s, loads0;
        in_ch.valid     = 1'b0;
        in_ch.element   = '0;
        in_ch.to_right  = 1'b0;
        out_ch.ready    = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = CFG_ROWS_A;
        cfg_ch.data     = '0;
        i_rst_n         = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: 2x2x2 with extreme values, saturating both ways
        set_dims(4'd2, 4'd2, 4'd2);
        void'(queue_element(Q_MAX, 1'b0, 1'b0));
        void'(queue_element(Q_MAX, 1'b0, 1'b0));
        void'(queue_element(Q_MIN, 1'b0, 1'b0));
        void'(queue_element(Q_MIN, 1'b0, 1'b0));
        // A already full: ignored
        void'(queue_element(32'sh1234_5678, 1'b0, 1'b0));
        void'(queue_element(Q_MAX, 1'b1, 1'b0));
        void'(queue_element(Q_MIN, 1'b1, 1'b0));
        void'(queue_element(Q_MAX, 1'b1, 1'b0));
        void'(queue_element(Q_MIN, 1'b1, 1'b0));
        // B finished before A; waits for the previous products first
        void'(queue_element('0, 1'b0, 1'b1));
        void'(queue_element(32'sh0001_0000, 1'b1, 1'b0));
        void'(queue_element(32'shFFFF_0000, 1'b1, 1'b0));
        void'(queue_element(32'sh0000_0001, 1'b1, 1'b0));
        void'(queue_element('1, 1'b1, 1'b0));
        // Partial loads, then shrink the dimensions below the counters
        void'(queue_element(32'sh0001_8000, 1'b0, 1'b0));
        void'(queue_element(32'shFFFE_8000, 1'b0, 1'b0));
        void'(queue_element(Q_MAX, 1'b0, 1'b0));
        void'(queue_element(32'sh0002_0000, 1'b1, 1'b0));
        void'(queue_element(32'shFFFF_8000, 1'b1, 1'b0));
        void'(queue_element(32'sh0000_8000, 1'b1, 1'b0));
        set_dims(4'd2, 4'd1, 4'd0);
        void'(queue_element(32'sh0003_0000, 1'b0, 1'b0));  // counter past size: dropped
        void'(queue_element(32'sh0004_0000, 1'b1, 1'b0));  // fires the product at once

        // Random phases, two dimension settings each
        for (ph = 0; ph < 4; ph++) begin
            for (s = 0; s < 2; s++) begin
                if (ph == 0 && s == 0)      set_dims(4'd0, 4'd0, 4'd0);
                else if (ph == 1 && s == 1) set_dims(4'd15, 4'd1, 4'd15);
                else if (ph == 2 && s == 1) set_dims(4'd1, 4'd15, 4'd1);
                else                        set_dims(rand_dim(), rand_dim(), rand_dim());
                case (ph)
                    0:       begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                    1:       begin src_idle_pct = 46; snk_stall_pct = 0;  end
                    2:       begin src_idle_pct = 0;  snk_stall_pct = 46; end
                    default: begin src_idle_pct = 17; snk_stall_pct = 17; end
                endcase
                loads0 = gen_loads;
                while (gen_loads - loads0 < SETTING_LOADS) begin
                    if ($urandom_range(3) != 0) begin
                        queue_product($urandom_range(7) == 0);
                    end else begin
                        // noise and broken sequences
                        case ($urandom_range(2))
                            0: begin
                                if ($urandom_range(1)) void'(queue_right(rand_elem(), 1'b0));
                                else void'(queue_element(rand_elem(), 1'b0, 1'b0));
                            end
                            1: repeat ($urandom_range(1, 5))
                                   void'(queue_element(rand_elem(), 1'b0, 1'b0));
                            default: repeat ($urandom_range(1, 5))
                                   void'(queue_right(rand_elem(), 1'b0));
                        endcase
                    end
                end
            end
        end

        wait_quiet();
        if (product_q.size() != 0)
            note_error($sformatf("%0d expected products never arrived", product_q.size()));
        $display("Run covered %0d elements over %0d register writes, %0d products checked",
                 n_items, n_cfg_writes, n_products);
        $display("of which %0d clipped to the Q16.16 range, %0d errors", n_clipped, n_errors);
        if (n_errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
